@@ sv/bst_pkg.sv @@
// shared constants, request codes and control structs for the bounded set table
// depends on nothing; imported by bst_ctrl, bst_dp and bounded_set_table_top
package bst_pkg;

  localparam int CAPACITY  = 32;
  localparam int KEY_WIDTH = 32;
  localparam int IDX_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int KIND_W    = 2;

  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic start;       // latch request, reset scan
    logic scan;        // one scan step
    logic set_reject;  // insert refused, table full
    logic insert;      // store key at slot count
    logic rd_last;     // read last used entry
    logic move;        // last entry into freed slot
    logic load;        // load result register
  } bst_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic              hit;
    logic              miss;
    logic              present;
    logic              full;
    logic              out_busy;
    logic [KIND_W-1:0] kind;
  } bst_stat_t;

endpackage

@@ sv/bst_ctrl.sv @@
// request sequencer for the bounded set table: scan, decide, write back, report
// depends on bst_pkg
module bst_ctrl import bst_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  bst_stat_t stat,
  output bst_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_MOVE,
    ST_RESULT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.hit || stat.miss) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_nxt = ST_RESULT;
        if (stat.kind == KIND_INSERT && !stat.present) begin
          if (stat.full) begin
            cmd.set_reject = 1'b1;
          end else begin
            cmd.insert = 1'b1;
          end
        end else if (stat.kind == KIND_REMOVE && stat.present) begin
          cmd.rd_last = 1'b1;
          state_nxt   = ST_MOVE;
        end
      end
      ST_MOVE: begin
        cmd.move  = 1'b1;
        state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (!stat.out_busy) begin
          cmd.load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/bst_dp.sv @@
// datapath of the bounded set table: key memory, scan pointer, count, result register
// depends on bst_pkg
module bst_dp import bst_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [KEY_WIDTH-1:0] in_key,
  input  bst_cmd_t             cmd,
  output bst_stat_t            stat,
  input  logic                 out_ready,
  output logic                 out_valid,
  output logic                 out_was_present,
  output logic [IDX_W-1:0]     out_slot,
  output logic [CNT_W-1:0]     out_entry_count,
  output logic                 out_full_reject
);

  logic [KEY_WIDTH-1:0] mem [CAPACITY];
  logic [KEY_WIDTH-1:0] rd_data_r;

  logic [KIND_W-1:0]    kind_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     rd_ptr_r;
  logic [IDX_W-1:0]     cmp_idx_r;
  logic                 cmp_valid_r;
  logic                 present_r;
  logic [IDX_W-1:0]     slot_r;
  logic                 reject_r;
  logic                 out_valid_r;
  logic                 out_present_r;
  logic [IDX_W-1:0]     out_slot_r;
  logic [CNT_W-1:0]     out_count_r;
  logic                 out_reject_r;

  logic                 issue;
  logic                 rd_en;
  logic [IDX_W-1:0]     rd_addr;
  logic [CNT_W-1:0]     last_cnt;
  logic                 hit;
  logic                 miss;

  assign last_cnt = count_r - CNT_W'(1);
  assign issue    = cmd.scan && (rd_ptr_r < count_r);
  assign rd_en    = issue || cmd.rd_last;
  assign rd_addr  = cmd.rd_last ? last_cnt[IDX_W-1:0] : rd_ptr_r[IDX_W-1:0];
  assign hit      = cmp_valid_r && (rd_data_r == key_r);
  assign miss     = (count_r == '0)
                  || (cmp_valid_r && !hit && ({1'b0, cmp_idx_r} == last_cnt));

  assign stat.hit      = hit;
  assign stat.miss     = miss;
  assign stat.present  = present_r;
  assign stat.full     = (count_r == CAP_CNT);
  assign stat.out_busy = out_valid_r && !out_ready;
  assign stat.kind     = kind_r;

  // key memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    if (cmd.insert) begin
      mem[count_r[IDX_W-1:0]] <= key_r;
    end else if (cmd.move) begin
      mem[slot_r] <= rd_data_r;
    end
  end

  // request payload and scan bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      kind_r    <= in_kind;
      key_r     <= in_key;
      rd_ptr_r  <= '0;
      present_r <= 1'b0;
      slot_r    <= '0;
      reject_r  <= 1'b0;
    end else begin
      if (issue) begin
        rd_ptr_r <= rd_ptr_r + CNT_W'(1);
      end
      if (cmd.scan && hit) begin
        present_r <= 1'b1;
        slot_r    <= cmp_idx_r;
      end
      if (cmd.insert) begin
        slot_r <= count_r[IDX_W-1:0];
      end
      if (cmd.set_reject) begin
        reject_r <= 1'b1;
      end
    end
    cmp_idx_r <= rd_ptr_r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cmp_valid_r <= issue;
      if (cmd.insert) begin
        count_r <= count_r + CNT_W'(1);
      end else if (cmd.move) begin
        count_r <= last_cnt;
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_present_r <= present_r;
      out_slot_r    <= slot_r;
      out_count_r   <= count_r;
      out_reject_r  <= reject_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_was_present = out_present_r;
  assign out_slot        = out_slot_r;
  assign out_entry_count = out_count_r;
  assign out_full_reject = out_reject_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT) else $error("entry count above capacity");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.insert |-> count_r != CAP_CNT) else $error("insert into full table");

  a_move_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.move |=> count_r == $past(count_r) - CNT_W'(1))
    else $error("remove did not lower count");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !(out_valid_r && !out_ready)) else $error("result overwritten");

endmodule

@@ sv/bounded_set_table_top.sv @@
// top level of the bounded set table: request sequencer plus key datapath
// depends on bst_pkg, bst_ctrl, bst_dp
//
// the table holds up to 32 distinct 32-bit keys in a memory with one write and
// one registered read port, with a count of entries in use; every request
// (insert, remove, lookup, with the unused kind code acting as a lookup) gives
// exactly one result transfer carrying was_present, slot, entry_count and
// full_reject. one request is handled at a time: the match scan reads one
// stored key per cycle through the registered memory read port, and a remove
// of a present key then reads the last entry and writes it into the freed
// slot. the key memory has no reset; entries at or above the count are never
// read. a finished result sits in the output register, and the next request
// is accepted the cycle after it has been loaded there.
module bounded_set_table_top import bst_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [KIND_W-1:0]    in_kind,
  input  logic [KEY_WIDTH-1:0] in_key,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_was_present,
  output logic [IDX_W-1:0]     out_slot,
  output logic [CNT_W-1:0]     out_entry_count,
  output logic                 out_full_reject
);

  bst_cmd_t  cmd;
  bst_stat_t stat;

  // state machine: idle, scan, decide, move, result
  bst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // key memory, scan compare, count and output register
  bst_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_kind         (in_kind),
    .in_key          (in_key),
    .cmd             (cmd),
    .stat            (stat),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_was_present (out_was_present),
    .out_slot        (out_slot),
    .out_entry_count (out_entry_count),
    .out_full_reject (out_full_reject)
  );

endmodule

@@ bench/bounded_set_table_top_tb.sv @@
// self-checking bench for bounded_set_table_top: insert, remove and lookup transfers
// with a local table predictor and random idling on both channels; depends on bst_pkg
`timescale 1ns / 100ps

module bounded_set_table_top_tb;
  import bst_pkg::*;

  // the unused kind code behaves as a lookup
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS = 1350;
  localparam int DRAIN_CYCLES = 60;
  localparam int LONG_HOLD    = 500;       // receiver hold-off that backs up the input
  localparam int HOLD_EVERY   = 600;       // results between hold-offs

  typedef struct {
    logic [KIND_W-1:0]    kind;
    logic [KEY_WIDTH-1:0] key;
  } request_t;

  typedef struct {
    logic             was_present;
    logic [IDX_W-1:0] slot;
    logic [CNT_W-1:0] entry_count;
    logic             full_reject;
  } reply_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [KIND_W-1:0]    in_kind = '0;
  logic [KEY_WIDTH-1:0] in_key = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic                 out_was_present;
  logic [IDX_W-1:0]     out_slot;
  logic [CNT_W-1:0]     out_entry_count;
  logic                 out_full_reject;

  request_t request_q[$];        // requests not yet offered to the block
  reply_t   predicted_replies[$]; // expected results, oldest first

  // local copy of the table, advanced at each accepted request
  logic [KEY_WIDTH-1:0] shadow_keys[CAPACITY];
  int                   shadow_count;

  int fail_count = 0;

  bounded_set_table_top dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_key          (in_key),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_was_present (out_was_present),
    .out_slot        (out_slot),
    .out_entry_count (out_entry_count),
    .out_full_reject (out_full_reject)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // linear match over the slots in use, then the table update for this request
  function automatic reply_t apply_request(logic [KIND_W-1:0] kind,
                                           logic [KEY_WIDTH-1:0] key);
    reply_t r;
    int     pos;
    bit     hit;
    pos = 0;
    while (pos < shadow_count && shadow_keys[pos] != key) pos++;
    hit = (pos < shadow_count);
    r.was_present = hit;
    r.slot = hit ? IDX_W'(pos) : '0;
    r.full_reject = 1'b0;
    case (kind)
      KIND_INSERT: begin
        if (!hit) begin
          if (shadow_count < CAPACITY) begin
            r.slot = IDX_W'(shadow_count);
            shadow_keys[shadow_count] = key;
            shadow_count++;
          end else begin
            r.full_reject = 1'b1;
          end
        end
      end
      KIND_REMOVE: begin
        // last entry fills the hole; a no-op when the key was the last one
        if (hit) begin
          shadow_keys[pos] = shadow_keys[shadow_count - 1];
          shadow_count--;
        end
      end
      default: ;
    endcase
    r.entry_count = CNT_W'(shadow_count);
    return r;
  endfunction

  // idle length: mostly none or short, now and then a long one
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic queue_request(logic [KIND_W-1:0] kind, logic [KEY_WIDTH-1:0] key);
    request_t req;
    req.kind = kind;
    req.key = key;
    request_q.push_back(req);
  endtask

  // driver: offers queued requests, predicts each one on its transfer
  int       gap_left;
  int       send_quiet_left;
  request_t next_req;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
      send_quiet_left = 0;
      shadow_count = 0;
    end else begin
      if (in_valid && in_ready) begin
        predicted_replies.push_back(apply_request(in_kind, in_key));
      end
      // the channel is free for a new item after this edge
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          next_req = request_q.pop_front();
          in_valid <= 1'b1;
          in_kind <= next_req.kind;
          in_key <= next_req.key;
          // occasional stretches of back-to-back items
          if (send_quiet_left > 0) begin
            send_quiet_left--;
            gap_left = 0;
          end else if ($urandom_range(0, 99) < 3) begin
            send_quiet_left = $urandom_range(30, 120);
            gap_left = 0;
          end else begin
            gap_left = pick_idle();
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks every result transfer against the oldest prediction
  int     stall_left;
  int     recv_quiet_left;
  int     replies_seen;
  int     next_hold_at;
  reply_t want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      recv_quiet_left = 0;
      replies_seen = 0;
      next_hold_at = 300;
    end else begin
      if (out_valid && out_ready) begin
        replies_seen++;
        if (predicted_replies.size() == 0) begin
          $error("result transfer with no request waiting");
          fail_count++;
        end else begin
          want = predicted_replies.pop_front();
          if (out_was_present !== want.was_present) begin
            $error("out_was_present mismatch: expected %0d, got %0d",
                   want.was_present, out_was_present);
            fail_count++;
          end
          if (out_slot !== want.slot) begin
            $error("out_slot mismatch: expected %0d, got %0d", want.slot, out_slot);
            fail_count++;
          end
          if (out_entry_count !== want.entry_count) begin
            $error("out_entry_count mismatch: expected %0d, got %0d",
                   want.entry_count, out_entry_count);
            fail_count++;
          end
          if (out_full_reject !== want.full_reject) begin
            $error("out_full_reject mismatch: expected %0d, got %0d",
                   want.full_reject, out_full_reject);
            fail_count++;
          end
        end
      end
      // long hold-off now and then so the block backs up and stalls its input
      if (replies_seen >= next_hold_at) begin
        next_hold_at += HOLD_EVERY;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (recv_quiet_left > 0) begin
          recv_quiet_left--;
        end else if ($urandom_range(0, 99) < 2) begin
          recv_quiet_left = $urandom_range(100, 300);
        end else begin
          stall_left = pick_idle();
        end
      end
    end
  end

  // stimulus and end of run
  logic [KEY_WIDTH-1:0] key_pool[64];
  int                   pool_size;
  int                   phase_len;
  int                   mode;
  int                   roll;
  int                   random_count;
  logic [KIND_W-1:0]    pick_kind;
  logic [KEY_WIDTH-1:0] pick_key;

  initial begin
    // empty table: lookup, remove of an absent key, unused kind
    queue_request(KIND_LOOKUP, 32'h0000_0000);
    queue_request(KIND_REMOVE, 32'hFFFF_FFFF);
    queue_request(KIND_UNUSED, 32'h0000_0000);
    // extreme keys, then insert of a present key
    queue_request(KIND_INSERT, 32'h0000_0000);
    queue_request(KIND_INSERT, 32'hFFFF_FFFF);
    queue_request(KIND_INSERT, 32'h0000_0001);
    queue_request(KIND_INSERT, 32'h8000_0000);
    queue_request(KIND_INSERT, 32'hFFFF_FFFF);
    queue_request(KIND_LOOKUP, 32'hFFFF_FFFF);
    queue_request(KIND_UNUSED, 32'h0000_0001);
    queue_request(KIND_LOOKUP, 32'h7FFF_FFFF);
    // remove from the first slot: last entry moves down
    queue_request(KIND_REMOVE, 32'h0000_0000);
    queue_request(KIND_LOOKUP, 32'h8000_0000);
    // remove of the last entry, then of an absent key
    queue_request(KIND_REMOVE, 32'h0000_0001);
    queue_request(KIND_REMOVE, 32'h1234_5678);
    queue_request(KIND_LOOKUP, 32'hFFFF_FFFF);
    queue_request(KIND_INSERT, 32'h0000_0000);
    // remove from the middle
    queue_request(KIND_REMOVE, 32'hFFFF_FFFF);
    queue_request(KIND_LOOKUP, 32'h0000_0000);
    queue_request(KIND_REMOVE, 32'h0000_0000);
    queue_request(KIND_REMOVE, 32'h8000_0000);
    queue_request(KIND_INSERT, 32'h5555_AAAA);

    // random phases over a key pool; pools larger than the table drive it full
    // so inserts of new keys get refused, small pools keep it partly used
    random_count = 0;
    while (random_count < RANDOM_ITEMS) begin
      pool_size = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 16)
                                              : $urandom_range(33, 56);
      for (int i = 0; i < pool_size; i++) key_pool[i] = $urandom();
      if ($urandom_range(0, 3) == 0) begin
        key_pool[0] = '0;
        key_pool[1] = '1;
      end
      phase_len = $urandom_range(40, 160);
      mode = $urandom_range(0, 2);   // 0 fill, 1 drain, 2 mixed
      for (int j = 0; j < phase_len && random_count < RANDOM_ITEMS; j++) begin
        roll = $urandom_range(0, 99);
        case (mode)
          0: pick_kind = (roll < 65) ? KIND_INSERT : (roll < 80) ? KIND_REMOVE :
                         (roll < 96) ? KIND_LOOKUP : KIND_UNUSED;
          1: pick_kind = (roll < 20) ? KIND_INSERT : (roll < 75) ? KIND_REMOVE :
                         (roll < 96) ? KIND_LOOKUP : KIND_UNUSED;
          default: pick_kind = (roll < 40) ? KIND_INSERT : (roll < 75) ? KIND_REMOVE :
                               (roll < 95) ? KIND_LOOKUP : KIND_UNUSED;
        endcase
        // a few keys from outside the pool, mostly misses
        pick_key = ($urandom_range(0, 99) < 8) ? $urandom()
                                               : key_pool[$urandom_range(0, pool_size - 1)];
        queue_request(pick_kind, pick_key);
        random_count++;
      end
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (request_q.size() > 0 || in_valid || predicted_replies.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && predicted_replies.size() == 0) begin
      $display("[bounded_set_table_top] OK");
    end else begin
      $display("[bounded_set_table_top] ERROR");
    end
    $finish;
  end

  // run limit: several times the slowest legal run
  initial begin
    #2000000;
    $display("[bounded_set_table_top] ERROR");
    $finish;
  end

endmodule
